### sv/ipacl_pkg.sv
// ----------------------------------------------------------------------------
// ipacl_pkg
// Shared types, codes and defaults for the IP/port range access-control check.
// ----------------------------------------------------------------------------
`default_nettype none

package ipacl_pkg;

	// Default sizes of the rule table, the member table and the group space.
	localparam int RULE_DEPTH_DEF   = 64;
	localparam int MEMBER_DEPTH_DEF = 64;
	localparam int GROUP_COUNT_DEF  = 16;

	// Function codes of an input word.
	localparam logic [2:0] FUNC_LOOKUP   = 3'd0;
	localparam logic [2:0] FUNC_ADD_RULE = 3'd1;
	localparam logic [2:0] FUNC_DEL_RULE = 3'd2;
	localparam logic [2:0] FUNC_ADD_MEM  = 3'd3;
	localparam logic [2:0] FUNC_DEL_MEM  = 3'd4;

	// Address kinds.
	localparam logic [1:0] KIND_V4    = 2'd0;
	localparam logic [1:0] KIND_V6    = 2'd1;
	localparam logic [1:0] KIND_GROUP = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CHECK   = 2'd0;
	localparam logic [1:0] CFG_ENFORCE = 2'd1;
	localparam logic [1:0] CFG_LEARN   = 2'd2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		VD_TABLE      = 3'd0,
		VD_MATCHED    = 3'd1,
		VD_UNCHECKED  = 3'd2,
		VD_DENIED     = 3'd3,
		VD_LEARNED    = 3'd4,
		VD_PERMISSIVE = 3'd5
	} verdict_t;

	// Which index goes out with a result.
	typedef enum logic [1:0] {
		IDX_ZERO  = 2'd0,
		IDX_RULE  = 2'd1,
		IDX_COUNT = 2'd2
	} idx_sel_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  kind;
		logic [3:0]  grp;
		logic [63:0] lo_hi;
		logic [63:0] lo_lo;
		logic [63:0] hi_hi;
		logic [63:0] hi_lo;
		logic [15:0] pmin;
		logic [15:0] pmax;
	} rule_body_t;

	typedef struct packed {
		logic       del;
		rule_body_t body;
	} rule_t;

	typedef struct packed {
		logic        v6;
		logic [3:0]  grp;
		logic [63:0] lo_hi;
		logic [63:0] lo_lo;
		logic [63:0] hi_hi;
		logic [63:0] hi_lo;
	} mem_body_t;

	typedef struct packed {
		logic      del;
		mem_body_t body;
	} mem_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     rclr;
		logic     rinc;
		logic     mclr;
		logic     minc;
		logic     rrd;
		logic     mrd;
		logic     rapp;
		logic     rupd;
		logic     mapp;
		logic     mupd;
		logic     del_val;
		logic     set_res;
		status_t  res_status;
		verdict_t res_verdict;
		idx_sel_t res_idx;
		logic     emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_lookup;
		logic is_rule_op;
		logic is_rule_del;
		logic is_mem_op;
		logic is_mem_del;
		logic req_bad;
		logic look_kind_ok;
		logic check_en;
		logic enforce;
		logic learn;
		logic r_end;
		logic m_end;
		logic r_full;
		logic m_full;
		logic rule_hit;
		logic rule_grp;
		logic mem_hit;
		logic find_hit;
		logic mfind_hit;
	} stat_t;

endpackage

`default_nettype wire

### sv/ipacl_ram.sv
// ----------------------------------------------------------------------------
// ipacl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ipacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### sv/ipacl_ctrl.sv
// ----------------------------------------------------------------------------
// ipacl_ctrl
// Sequencer for lookups, rule scans, member scans and table updates.
// ----------------------------------------------------------------------------
`default_nettype none

module ipacl_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            out_ready,
	output logic                 out_valid,
	input  wire ipacl_pkg::stat_t st,
	output ipacl_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_RREQ, S_RCHK, S_MREQ, S_MCHK,
		S_FREQ, S_FCHK, S_MFREQ, S_MFCHK, S_FIN
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Helper to post a result in the same cycle.
	function automatic ipacl_pkg::cmd_t post(ipacl_pkg::cmd_t c, ipacl_pkg::status_t s,
		ipacl_pkg::verdict_t v, ipacl_pkg::idx_sel_t x);
		ipacl_pkg::cmd_t r;
		r             = c;
		r.set_res     = 1'b1;
		r.res_status  = s;
		r.res_verdict = v;
		r.res_idx     = x;
		return r;
	endfunction

	always_comb begin
		ipacl_pkg::verdict_t vt;
		cmd     = '0;
		state_d = state_q;
		vt      = st.is_lookup ? ipacl_pkg::VD_LEARNED : ipacl_pkg::VD_TABLE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FIN;
				if (st.is_lookup) begin
					if (!st.check_en) begin
						cmd = post(cmd, ipacl_pkg::ST_OK, ipacl_pkg::VD_UNCHECKED,
							ipacl_pkg::IDX_ZERO);
					end else if (!st.look_kind_ok) begin
						cmd = post(cmd, ipacl_pkg::ST_OK, st.enforce ? ipacl_pkg::VD_DENIED :
							ipacl_pkg::VD_PERMISSIVE, ipacl_pkg::IDX_ZERO);
					end else begin
						cmd.rclr = 1'b1;
						state_d  = S_RREQ;
					end
				end else if (st.is_rule_op && !st.req_bad) begin
					cmd.rclr = 1'b1;
					state_d  = S_FREQ;
				end else if (st.is_mem_op && !st.req_bad) begin
					cmd.mclr = 1'b1;
					state_d  = S_MFREQ;
				end else begin
					cmd = post(cmd, ipacl_pkg::ST_NOTFOUND, ipacl_pkg::VD_TABLE,
						ipacl_pkg::IDX_ZERO);
				end
			end
			S_RREQ: begin
				if (st.r_end) begin
					if (st.enforce) begin
						cmd     = post(cmd, ipacl_pkg::ST_OK, ipacl_pkg::VD_DENIED,
							ipacl_pkg::IDX_ZERO);
						state_d = S_FIN;
					end else if (st.learn) begin
						cmd.rclr = 1'b1;
						state_d  = S_FREQ;
					end else begin
						cmd     = post(cmd, ipacl_pkg::ST_OK, ipacl_pkg::VD_PERMISSIVE,
							ipacl_pkg::IDX_ZERO);
						state_d = S_FIN;
					end
				end else begin
					cmd.rrd = 1'b1;
					state_d = S_RCHK;
				end
			end
			S_RCHK: begin
				if (st.rule_hit) begin
					cmd     = post(cmd, ipacl_pkg::ST_OK, ipacl_pkg::VD_MATCHED,
						ipacl_pkg::IDX_RULE);
					state_d = S_FIN;
				end else if (st.rule_grp) begin
					cmd.mclr = 1'b1;
					state_d  = S_MREQ;
				end else begin
					cmd.rinc = 1'b1;
					state_d  = S_RREQ;
				end
			end
			S_MREQ: begin
				if (st.m_end) begin
					cmd.rinc = 1'b1;
					state_d  = S_RREQ;
				end else begin
					cmd.mrd = 1'b1;
					state_d = S_MCHK;
				end
			end
			S_MCHK: begin
				if (st.mem_hit) begin
					cmd     = post(cmd, ipacl_pkg::ST_OK, ipacl_pkg::VD_MATCHED,
						ipacl_pkg::IDX_RULE);
					state_d = S_FIN;
				end else begin
					cmd.minc = 1'b1;
					state_d  = S_MREQ;
				end
			end
			S_FREQ: begin
				if (st.r_end) begin
					state_d = S_FIN;
					if (st.is_rule_del) begin
						cmd = post(cmd, ipacl_pkg::ST_NOTFOUND, ipacl_pkg::VD_TABLE,
							ipacl_pkg::IDX_ZERO);
					end else if (st.r_full) begin
						cmd = post(cmd, ipacl_pkg::ST_FULL, st.is_lookup ?
							ipacl_pkg::VD_PERMISSIVE : ipacl_pkg::VD_TABLE, ipacl_pkg::IDX_ZERO);
					end else begin
						cmd      = post(cmd, ipacl_pkg::ST_OK, vt, ipacl_pkg::IDX_COUNT);
						cmd.rapp = 1'b1;
					end
				end else begin
					cmd.rrd = 1'b1;
					state_d = S_FCHK;
				end
			end
			S_FCHK: begin
				if (st.find_hit) begin
					cmd         = post(cmd, ipacl_pkg::ST_OK, vt, ipacl_pkg::IDX_RULE);
					cmd.rupd    = 1'b1;
					cmd.del_val = st.is_rule_del;
					state_d     = S_FIN;
				end else begin
					cmd.rinc = 1'b1;
					state_d  = S_FREQ;
				end
			end
			S_MFREQ: begin
				if (st.m_end) begin
					state_d = S_FIN;
					if (st.is_mem_del) begin
						cmd = post(cmd, ipacl_pkg::ST_NOTFOUND, ipacl_pkg::VD_TABLE,
							ipacl_pkg::IDX_ZERO);
					end else if (st.m_full) begin
						cmd = post(cmd, ipacl_pkg::ST_FULL, ipacl_pkg::VD_TABLE,
							ipacl_pkg::IDX_ZERO);
					end else begin
						cmd      = post(cmd, ipacl_pkg::ST_OK, ipacl_pkg::VD_TABLE,
							ipacl_pkg::IDX_ZERO);
						cmd.mapp = 1'b1;
					end
				end else begin
					cmd.mrd = 1'b1;
					state_d = S_MFCHK;
				end
			end
			S_MFCHK: begin
				if (st.mfind_hit) begin
					cmd         = post(cmd, ipacl_pkg::ST_OK, ipacl_pkg::VD_TABLE,
						ipacl_pkg::IDX_ZERO);
					cmd.mupd    = 1'b1;
					cmd.del_val = st.is_mem_del;
					state_d     = S_FIN;
				end else begin
					cmd.minc = 1'b1;
					state_d  = S_MFREQ;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### sv/ipacl_dp.sv
// ----------------------------------------------------------------------------
// ipacl_dp
// Key registers, table memories, scan counters, comparators and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ipacl_dp #(
	parameter int RULE_DEPTH   = ipacl_pkg::RULE_DEPTH_DEF,
	parameter int MEMBER_DEPTH = ipacl_pkg::MEMBER_DEPTH_DEF,
	parameter int GROUP_COUNT  = ipacl_pkg::GROUP_COUNT_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_index,
	input  wire logic            cfg_data,
	input  wire logic [2:0]      func,
	input  wire logic [1:0]      record_kind,
	input  wire logic [2:0]      operation,
	input  wire logic [3:0]      group_id,
	input  wire logic [63:0]     addr_min_hi,
	input  wire logic [63:0]     addr_min_lo,
	input  wire logic [63:0]     addr_max_hi,
	input  wire logic [63:0]     addr_max_lo,
	input  wire logic [15:0]     port_min,
	input  wire logic [15:0]     port_max,
	input  wire ipacl_pkg::cmd_t cmd,
	output ipacl_pkg::stat_t     st,
	output logic [1:0]           status,
	output logic [2:0]           verdict,
	output logic [5:0]           matched_rule
);

	localparam int RAW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
	localparam int MAW = (MEMBER_DEPTH > 1) ? $clog2(MEMBER_DEPTH) : 1;
	localparam int RCW = $clog2(RULE_DEPTH + 1);
	localparam int MCW = $clog2(MEMBER_DEPTH + 1);

	logic                  check_q, enforce_q, learn_q;
	logic [2:0]            func_q;
	logic [1:0]            kind_q;
	logic [3:0]            gid_q;
	ipacl_pkg::rule_body_t key_q;
	logic [RCW-1:0]        rcount_q, ridx_q;
	logic [MCW-1:0]        mcount_q, midx_q;
	logic [1:0]            res_status_q;
	logic [2:0]            res_verdict_q;
	logic [5:0]            res_idx_q;
	logic [1:0]            status_q;
	logic [2:0]            verdict_q;
	logic [5:0]            matched_q;

	ipacl_pkg::rule_t      r_rd, r_wr;
	ipacl_pkg::mem_t       m_rd, m_wr;
	ipacl_pkg::mem_body_t  mkey;
	ipacl_pkg::rule_body_t nkey;
	logic [127:0]          look_addr;
	logic [31:0]           ridx_w, rcount_w;
	logic                  gid_bad;

	// Normalized key for the incoming word.
	always_comb begin
		nkey       = '0;
		nkey.op    = operation;
		nkey.kind  = record_kind;
		nkey.pmin  = port_min;
		nkey.pmax  = (func == ipacl_pkg::FUNC_LOOKUP) ? port_min : port_max;
		if (record_kind == ipacl_pkg::KIND_GROUP) begin
			nkey.grp = group_id;
		end
		if (record_kind == ipacl_pkg::KIND_V4) begin
			nkey.lo_lo = {32'd0, addr_min_lo[31:0]};
			nkey.hi_lo = {32'd0, addr_max_lo[31:0]};
		end else if (record_kind == ipacl_pkg::KIND_V6) begin
			nkey.lo_hi = addr_min_hi;
			nkey.lo_lo = addr_min_lo;
			nkey.hi_hi = addr_max_hi;
			nkey.hi_lo = addr_max_lo;
		end
		// A learned rule is the exact lookup address.
		if (func == ipacl_pkg::FUNC_LOOKUP) begin
			nkey.hi_hi = nkey.lo_hi;
			nkey.hi_lo = nkey.lo_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_q   <= 1'b0;
			enforce_q <= 1'b0;
			learn_q   <= 1'b0;
			rcount_q  <= '0;
			mcount_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ipacl_pkg::CFG_CHECK:   check_q   <= cfg_data;
					ipacl_pkg::CFG_ENFORCE: enforce_q <= cfg_data;
					ipacl_pkg::CFG_LEARN:   learn_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.rapp) begin
				rcount_q <= rcount_q + 1'b1;
			end
			if (cmd.mapp) begin
				mcount_q <= mcount_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			kind_q <= record_kind;
			gid_q  <= group_id;
			key_q  <= nkey;
		end
		if (cmd.rclr) begin
			ridx_q <= '0;
		end else if (cmd.rinc) begin
			ridx_q <= ridx_q + 1'b1;
		end
		if (cmd.mclr) begin
			midx_q <= '0;
		end else if (cmd.minc) begin
			midx_q <= midx_q + 1'b1;
		end
		if (cmd.set_res) begin
			res_status_q  <= cmd.res_status;
			res_verdict_q <= cmd.res_verdict;
			case (cmd.res_idx)
				ipacl_pkg::IDX_RULE:  res_idx_q <= ridx_w[5:0];
				ipacl_pkg::IDX_COUNT: res_idx_q <= rcount_w[5:0];
				default:              res_idx_q <= '0;
			endcase
		end
		if (cmd.emit) begin
			status_q  <= res_status_q;
			verdict_q <= res_verdict_q;
			matched_q <= res_idx_q;
		end
	end

	assign ridx_w   = 32'(ridx_q);
	assign rcount_w = 32'(rcount_q);

	assign mkey.v6    = kind_q[0];
	assign mkey.grp   = gid_q;
	assign mkey.lo_hi = key_q.lo_hi;
	assign mkey.lo_lo = key_q.lo_lo;
	assign mkey.hi_hi = key_q.hi_hi;
	assign mkey.hi_lo = key_q.hi_lo;

	assign r_wr.del  = cmd.rupd ? cmd.del_val : 1'b0;
	assign r_wr.body = key_q;
	assign m_wr.del  = cmd.mupd ? cmd.del_val : 1'b0;
	assign m_wr.body = mkey;

	ipacl_ram #(.WIDTH($bits(ipacl_pkg::rule_t)), .DEPTH(RULE_DEPTH)) u_rule_ram (
		.clk     (clk),
		.we      (cmd.rapp | cmd.rupd),
		.wr_addr (cmd.rapp ? rcount_q[RAW-1:0] : ridx_q[RAW-1:0]),
		.wr_data (r_wr),
		.re      (cmd.rrd),
		.rd_addr (ridx_q[RAW-1:0]),
		.rd_data (r_rd)
	);

	ipacl_ram #(.WIDTH($bits(ipacl_pkg::mem_t)), .DEPTH(MEMBER_DEPTH)) u_mem_ram (
		.clk     (clk),
		.we      (cmd.mapp | cmd.mupd),
		.wr_addr (cmd.mapp ? mcount_q[MAW-1:0] : midx_q[MAW-1:0]),
		.wr_data (m_wr),
		.re      (cmd.mrd),
		.rd_addr (midx_q[MAW-1:0]),
		.rd_data (m_rd)
	);

	assign look_addr = {key_q.lo_hi, key_q.lo_lo};
	assign gid_bad   = (32'(gid_q) >= 32'(GROUP_COUNT));

	always_comb begin
		logic rule_pre;
		st             = '0;
		st.is_lookup   = (func_q == ipacl_pkg::FUNC_LOOKUP);
		st.is_rule_op  = (func_q == ipacl_pkg::FUNC_ADD_RULE) ||
			(func_q == ipacl_pkg::FUNC_DEL_RULE);
		st.is_rule_del = (func_q == ipacl_pkg::FUNC_DEL_RULE);
		st.is_mem_op   = (func_q == ipacl_pkg::FUNC_ADD_MEM) ||
			(func_q == ipacl_pkg::FUNC_DEL_MEM);
		st.is_mem_del  = (func_q == ipacl_pkg::FUNC_DEL_MEM);
		st.look_kind_ok = !kind_q[1];
		if (st.is_rule_op) begin
			st.req_bad = (kind_q == 2'd3) || ((kind_q == ipacl_pkg::KIND_GROUP) && gid_bad);
		end else begin
			st.req_bad = kind_q[1] || gid_bad;
		end
		st.check_en = check_q;
		st.enforce  = enforce_q;
		st.learn    = learn_q;
		st.r_end    = (ridx_q >= rcount_q);
		st.m_end    = (midx_q >= mcount_q);
		st.r_full   = (rcount_q == RCW'(RULE_DEPTH));
		st.m_full   = (mcount_q == MCW'(MEMBER_DEPTH));
		// Active rule with the same operation whose port range holds the port.
		rule_pre    = !r_rd.del && (r_rd.body.op == key_q.op) &&
			(key_q.pmin >= r_rd.body.pmin) && (key_q.pmin <= r_rd.body.pmax);
		st.rule_grp = rule_pre && (r_rd.body.kind == ipacl_pkg::KIND_GROUP);
		st.rule_hit = rule_pre && (r_rd.body.kind == kind_q) &&
			({r_rd.body.lo_hi, r_rd.body.lo_lo} <= look_addr) &&
			(look_addr <= {r_rd.body.hi_hi, r_rd.body.hi_lo});
		st.mem_hit  = !m_rd.del && (m_rd.body.grp == r_rd.body.grp) &&
			(m_rd.body.v6 == kind_q[0]) &&
			({m_rd.body.lo_hi, m_rd.body.lo_lo} <= look_addr) &&
			(look_addr <= {m_rd.body.hi_hi, m_rd.body.hi_lo});
		st.find_hit  = (r_rd.body == key_q) && !(st.is_rule_del && r_rd.del);
		st.mfind_hit = (m_rd.body == mkey);
	end

	assign status       = status_q;
	assign verdict      = verdict_q;
	assign matched_rule = matched_q;

endmodule

`default_nettype wire

### sv/ip_port_range_acl_check_core.sv
// ----------------------------------------------------------------------------
// ip_port_range_acl_check_core
// Ordered IP/port range rule table with address groups, learn and enforce.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake             Payload
// in       sink       in_valid / in_ready   func .. port_max, one word per item
// out      source     out_valid / out_ready status, verdict, matched_rule
// cfg      sink       cfg_we                cfg_index, cfg_data
//
// One word is handled at a time. A lookup reads the rule memory entry by
// entry; each group rule that passes the operation and port checks starts a
// scan of the member memory. Table updates scan until the first identical
// entry. The two tables live in registered-read RAMs, one read each cycle.
// Reset clears the counts, the modes and the controller state only; the RAMs
// need no clearing since only entries below the counts are ever read. A
// finished result waits in the output register while the next word is
// accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_port_range_acl_check_core #(
	parameter int RULE_DEPTH   = ipacl_pkg::RULE_DEPTH_DEF,
	parameter int MEMBER_DEPTH = ipacl_pkg::MEMBER_DEPTH_DEF,
	parameter int GROUP_COUNT  = ipacl_pkg::GROUP_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic        cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  func,
	input  wire logic [1:0]  record_kind,
	input  wire logic [2:0]  operation,
	input  wire logic [3:0]  group_id,
	input  wire logic [63:0] addr_min_hi,
	input  wire logic [63:0] addr_min_lo,
	input  wire logic [63:0] addr_max_hi,
	input  wire logic [63:0] addr_max_lo,
	input  wire logic [15:0] port_min,
	input  wire logic [15:0] port_max,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [2:0]       verdict,
	output logic [5:0]       matched_rule
);

	// The controller sequences scans; the datapath holds tables and compares.
	ipacl_pkg::cmd_t  cmd;
	ipacl_pkg::stat_t st;

	ipacl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.st        (st),
		.cmd       (cmd)
	);

	ipacl_dp #(
		.RULE_DEPTH   (RULE_DEPTH),
		.MEMBER_DEPTH (MEMBER_DEPTH),
		.GROUP_COUNT  (GROUP_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.func         (func),
		.record_kind  (record_kind),
		.operation    (operation),
		.group_id     (group_id),
		.addr_min_hi  (addr_min_hi),
		.addr_min_lo  (addr_min_lo),
		.addr_max_hi  (addr_max_hi),
		.addr_max_lo  (addr_max_lo),
		.port_min     (port_min),
		.port_max     (port_max),
		.cmd          (cmd),
		.st           (st),
		.status       (status),
		.verdict      (verdict),
		.matched_rule (matched_rule)
	);

endmodule

`default_nettype wire

### tb/sv/ip_port_range_acl_check_core_tb.sv
// ----------------------------------------------------------------------------
// ip_port_range_acl_check_core_tb
// Self-checking bench for the IP/port range rule table with address groups.
// Words are generated in phases under several mode settings, each response
// is predicted by a behavioral copy of the tables and compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_port_range_acl_check_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RDEPTH = 64;
	localparam int MDEPTH = 64;
	localparam int NGROUP = 16;
	// Settle bound, sized for the slowest word: a lookup that walks every rule,
	// each a group rule that walks every member.
	localparam int SETTLE = 10000;

	// One input word as it is driven onto the ports.
	typedef struct packed {
		logic [2:0]  fn;
		logic [1:0]  kind;
		logic [2:0]  op;
		logic [3:0]  grp;
		logic [63:0] lh;
		logic [63:0] ll;
		logic [63:0] hh;
		logic [63:0] hl;
		logic [15:0] pmin;
		logic [15:0] pmax;
	} acl_word_t;

	typedef struct packed {
		ipacl_pkg::status_t  st;
		ipacl_pkg::verdict_t vd;
		logic [5:0]          idx;
	} acl_resp_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic        cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  func;
	logic [1:0]  record_kind;
	logic [2:0]  operation;
	logic [3:0]  group_id;
	logic [63:0] addr_min_hi;
	logic [63:0] addr_min_lo;
	logic [63:0] addr_max_hi;
	logic [63:0] addr_max_lo;
	logic [15:0] port_min;
	logic [15:0] port_max;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [2:0]  verdict;
	logic [5:0]  matched_rule;

	ip_port_range_acl_check_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .record_kind(record_kind), .operation(operation),
		.group_id(group_id),
		.addr_min_hi(addr_min_hi), .addr_min_lo(addr_min_lo),
		.addr_max_hi(addr_max_hi), .addr_max_lo(addr_max_lo),
		.port_min(port_min), .port_max(port_max),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .verdict(verdict), .matched_rule(matched_rule)
	);

	// Shadow copy of the block's tables and modes.
	logic       mode_check, mode_enforce, mode_learn;
	int         n_rules, n_members;
	logic       rdel [RDEPTH];
	acl_word_t  rbody [RDEPTH];
	logic       mdel [MDEPTH];
	acl_word_t  mbody [MDEPTH];

	acl_word_t  word_queue [$];
	acl_resp_t  resp_queue [$];
	int         errors = 0;
	int         words_sent = 0;
	int         responses_seen = 0;
	// Pressure controls, set by the stimulus process.
	int         hold_out = 0;
	logic       sender_paused = 1'b0;
	// The pool of addresses that random words reuse, so that lookups hit.
	acl_word_t  pool [$];

	function automatic logic le128(logic [63:0] ah, logic [63:0] al,
			logic [63:0] bh, logic [63:0] bl);
		return {ah, al} <= {bh, bl};
	endfunction

	// Normalize addresses the way the block stores them.
	function automatic acl_word_t canon(acl_word_t w);
		acl_word_t c;
		c = w;
		if (c.kind == ipacl_pkg::KIND_V4) begin
			c.lh = '0;
			c.hh = '0;
			c.ll[63:32] = '0;
			c.hl[63:32] = '0;
		end
		if (c.kind >= ipacl_pkg::KIND_GROUP) begin
			c.lh = '0; c.ll = '0; c.hh = '0; c.hl = '0;
		end
		if (c.kind != ipacl_pkg::KIND_GROUP) c.grp = '0;
		return c;
	endfunction

	function automatic logic in_group(logic [3:0] g, logic v6, logic [63:0] ah,
			logic [63:0] al);
		for (int i = 0; i < n_members; i++) begin
			if (mdel[i] || mbody[i].grp != g || mbody[i].kind[0] != v6) continue;
			if (le128(mbody[i].lh, mbody[i].ll, ah, al) &&
					le128(ah, al, mbody[i].hh, mbody[i].hl))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Identical-rule search on operation, kind, group or addresses, ports.
	function automatic int find_same_rule(acl_word_t c, logic active_only);
		for (int i = 0; i < n_rules; i++) begin
			if (active_only && rdel[i]) continue;
			if (rbody[i].op != c.op || rbody[i].kind != c.kind) continue;
			if (rbody[i].pmin != c.pmin || rbody[i].pmax != c.pmax) continue;
			if (c.kind == ipacl_pkg::KIND_GROUP) begin
				if (rbody[i].grp != c.grp) continue;
			end else if (rbody[i].lh != c.lh || rbody[i].ll != c.ll ||
					rbody[i].hh != c.hh || rbody[i].hl != c.hl) begin
				continue;
			end
			return i;
		end
		return -1;
	endfunction

	function automatic ipacl_pkg::status_t insert_rule(acl_word_t c, output int idx);
		int f;
		f = find_same_rule(c, 1'b0);
		idx = 0;
		if (f >= 0) begin
			rdel[f] = 1'b0;
			idx = f;
			return ipacl_pkg::ST_OK;
		end
		if (n_rules >= RDEPTH) return ipacl_pkg::ST_FULL;
		rbody[n_rules] = c;
		rdel[n_rules] = 1'b0;
		idx = n_rules;
		n_rules++;
		return ipacl_pkg::ST_OK;
	endfunction

	// Computes the response to one word and updates the shadow tables.
	function automatic acl_resp_t classify_word(acl_word_t w);
		acl_resp_t r;
		acl_word_t c, lw;
		int idx, f;
		logic hit;
		logic [4:0] key;
		c = canon(w);
		r.st = ipacl_pkg::ST_OK;
		r.vd = ipacl_pkg::VD_TABLE;
		idx = 0;
		case (c.fn)
			ipacl_pkg::FUNC_LOOKUP: begin
				if (!mode_check) begin
					r.vd = ipacl_pkg::VD_UNCHECKED;
				end else begin
					hit = 1'b0;
					if (c.kind < ipacl_pkg::KIND_GROUP) begin
						for (int i = 0; i < n_rules; i++) begin
							if (rdel[i] || rbody[i].op != c.op) continue;
							if (c.pmin < rbody[i].pmin || rbody[i].pmax < c.pmin) continue;
							if (rbody[i].kind == ipacl_pkg::KIND_GROUP) begin
								if (!in_group(rbody[i].grp, c.kind[0], c.lh, c.ll)) continue;
							end else begin
								if (rbody[i].kind != c.kind) continue;
								if (!le128(rbody[i].lh, rbody[i].ll, c.lh, c.ll) ||
										!le128(c.lh, c.ll, rbody[i].hh, rbody[i].hl))
									continue;
							end
							hit = 1'b1;
							idx = i;
							break;
						end
					end
					if (hit) begin
						r.vd = ipacl_pkg::VD_MATCHED;
					end else if (mode_enforce) begin
						r.vd = ipacl_pkg::VD_DENIED;
					end else if (mode_learn && c.kind < ipacl_pkg::KIND_GROUP) begin
						// The learned rule is the exact address and port.
						lw = c;
						lw.grp = '0;
						lw.hh = c.lh;
						lw.hl = c.ll;
						lw.pmax = c.pmin;
						r.st = insert_rule(lw, idx);
						r.vd = (r.st == ipacl_pkg::ST_OK) ? ipacl_pkg::VD_LEARNED :
							ipacl_pkg::VD_PERMISSIVE;
					end else begin
						r.vd = ipacl_pkg::VD_PERMISSIVE;
					end
				end
			end
			ipacl_pkg::FUNC_ADD_RULE, ipacl_pkg::FUNC_DEL_RULE: begin
				if (c.kind == 2'd3) begin
					r.st = ipacl_pkg::ST_NOTFOUND;
				end else if (c.fn == ipacl_pkg::FUNC_ADD_RULE) begin
					r.st = insert_rule(c, idx);
				end else begin
					f = find_same_rule(c, 1'b1);
					if (f < 0) begin
						r.st = ipacl_pkg::ST_NOTFOUND;
					end else begin
						rdel[f] = 1'b1;
						idx = f;
					end
				end
			end
			ipacl_pkg::FUNC_ADD_MEM, ipacl_pkg::FUNC_DEL_MEM: begin
				if (c.kind >= ipacl_pkg::KIND_GROUP) begin
					r.st = ipacl_pkg::ST_NOTFOUND;
				end else begin
					key = {c.kind[0], w.grp};
					f = -1;
					for (int i = 0; i < n_members; i++) begin
						if ({mbody[i].kind[0], mbody[i].grp} != key) continue;
						if (mbody[i].lh != c.lh || mbody[i].ll != c.ll ||
								mbody[i].hh != c.hh || mbody[i].hl != c.hl)
							continue;
						f = i;
						break;
					end
					if (f >= 0) begin
						mdel[f] = (c.fn == ipacl_pkg::FUNC_DEL_MEM);
					end else if (c.fn == ipacl_pkg::FUNC_DEL_MEM) begin
						r.st = ipacl_pkg::ST_NOTFOUND;
					end else if (n_members >= MDEPTH) begin
						r.st = ipacl_pkg::ST_FULL;
					end else begin
						mbody[n_members] = c;
						mbody[n_members].grp = w.grp;
						mdel[n_members] = 1'b0;
						n_members++;
					end
				end
			end
			default: r.st = ipacl_pkg::ST_NOTFOUND;
		endcase
		if (r.st != ipacl_pkg::ST_OK) idx = 0;
		r.idx = idx[5:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch on response %0d: %s got %0d expected %0d",
			responses_seen, what, got, want);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: offers words from the queue, with a random gap before each.
	int gap_in = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_in <= 0;
		end else begin
			if (in_valid && in_ready) words_sent <= words_sent + 1;
			if (!in_valid || in_ready) begin
				if (gap_in > 0) begin
					gap_in <= gap_in - 1;
					in_valid <= 1'b0;
				end else if (word_queue.size() > 0 && !sender_paused) begin
					acl_word_t w;
					w = word_queue.pop_front();
					in_valid <= 1'b1;
					func <= w.fn; record_kind <= w.kind; operation <= w.op;
					group_id <= w.grp;
					addr_min_hi <= w.lh; addr_min_lo <= w.ll;
					addr_max_hi <= w.hh; addr_max_lo <= w.hl;
					port_min <= w.pmin; port_max <= w.pmax;
					resp_queue.push_back(classify_word(w));
					gap_in <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random backpressure and a comparison for every accepted word.
	int gap_out = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			gap_out <= 0;
		end else begin
			if (out_valid && out_ready) begin
				acl_resp_t e;
				responses_seen <= responses_seen + 1;
				if (resp_queue.size() == 0) begin
					report_mismatch("unexpected word, status", status, 0);
				end else begin
					e = resp_queue.pop_front();
					if (status !== e.st) report_mismatch("status", status, e.st);
					if (verdict !== e.vd) report_mismatch("verdict", verdict, e.vd);
					if (matched_rule !== e.idx)
						report_mismatch("matched_rule", matched_rule, e.idx);
				end
			end
			if (hold_out > 0) begin
				out_ready <= 1'b0;
			end else if (gap_out > 0) begin
				gap_out <= gap_out - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (out_valid && out_ready)
					gap_out <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			end
		end
	end

	// The long hold-off is counted here, apart from the per-word draws.
	always @(posedge clk) begin
		if (hold_out > 0) hold_out <= hold_out - 1;
	end

	task automatic wait_drained();
		while (word_queue.size() > 0 || in_valid || resp_queue.size() > 0)
			@(posedge clk);
		repeat (SETTLE / 20) @(posedge clk);
	endtask

	task automatic write_mode(logic [1:0] index, logic value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			ipacl_pkg::CFG_CHECK:   mode_check = value;
			ipacl_pkg::CFG_ENFORCE: mode_enforce = value;
			default:                mode_learn = value;
		endcase
	endtask

	task automatic set_modes(logic chk, logic enf, logic lrn);
		wait_drained();
		write_mode(ipacl_pkg::CFG_CHECK, chk);
		write_mode(ipacl_pkg::CFG_ENFORCE, enf);
		write_mode(ipacl_pkg::CFG_LEARN, lrn);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Builds an address range; some are full-width extremes.
	function automatic acl_word_t rand_range(logic [1:0] kind);
		acl_word_t w;
		logic [127:0] a, b;
		w = '0;
		w.kind = kind;
		a = {rand64(), rand64()};
		b = a + $urandom_range(0, 1000);
		case ($urandom_range(0, 5))
			0: begin a = '0; b = '1; end
			1: b = a;
			default: ;
		endcase
		if (b < a) b = a;
		{w.lh, w.ll} = a;
		{w.hh, w.hl} = b;
		w.grp = $urandom();
		return w;
	endfunction

	// A random word, mostly built around the address pool.
	function automatic acl_word_t rand_word();
		acl_word_t w, p;
		logic [127:0] a, lo, hi;
		int sel;
		sel = $urandom_range(0, 99);
		if (pool.size() == 0 || sel < 15) begin
			w = rand_range($urandom_range(0, 1));
			pool.push_back(w);
			if (pool.size() > 40) void'(pool.pop_front());
		end else begin
			w = pool[$urandom_range(0, pool.size() - 1)];
		end
		w.op = $urandom_range(0, 3);
		w.pmin = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 40);
		w.pmax = w.pmin + $urandom_range(0, 40);
		if (sel < 45) begin
			// Lookup at an address inside the range.
			w.fn = ipacl_pkg::FUNC_LOOKUP;
			lo = {w.lh, w.ll};
			hi = {w.hh, w.hl};
			a = lo + ((hi - lo) > 0 ? $urandom_range(0, 3) : 0);
			if (a > hi || a < lo) a = lo;
			if ($urandom_range(0, 7) == 0) a = {rand64(), rand64()};
			{w.lh, w.ll} = a;
			w.pmin = w.pmin + $urandom_range(0, 4);
		end else if (sel < 65) begin
			w.fn = ipacl_pkg::FUNC_ADD_RULE;
			if ($urandom_range(0, 3) == 0) w.kind = ipacl_pkg::KIND_GROUP;
		end else if (sel < 75) begin
			w.fn = ipacl_pkg::FUNC_DEL_RULE;
		end else if (sel < 87) begin
			w.fn = ipacl_pkg::FUNC_ADD_MEM;
		end else if (sel < 94) begin
			w.fn = ipacl_pkg::FUNC_DEL_MEM;
		end else begin
			// Noise: any code, any kind, raw fields.
			w.fn = $urandom();
			w.kind = $urandom();
			w.op = $urandom();
			w.hh = rand64();
			w.lh = rand64();
		end
		return w;
	endfunction

	function automatic acl_word_t mk(logic [2:0] fn, logic [1:0] kind, logic [2:0] op,
			logic [3:0] grp, logic [127:0] lo, logic [127:0] hi,
			logic [15:0] pmin, logic [15:0] pmax);
		acl_word_t w;
		w.fn = fn; w.kind = kind; w.op = op; w.grp = grp;
		{w.lh, w.ll} = lo;
		{w.hh, w.hl} = hi;
		w.pmin = pmin; w.pmax = pmax;
		return w;
	endfunction

	localparam logic [127:0] ALL1 = '1;
	localparam logic [127:0] V6A = 128'h2001_0db8_0000_0000_0000_0000_0000_0100;

	initial begin
		cfg_we = 1'b0; cfg_index = '0; cfg_data = 1'b0;
		in_valid = 1'b0; out_ready = 1'b0;
		func = '0; record_kind = '0; operation = '0; group_id = '0;
		addr_min_hi = '0; addr_min_lo = '0; addr_max_hi = '0; addr_max_lo = '0;
		port_min = '0; port_max = '0;
		mode_check = 0; mode_enforce = 0; mode_learn = 0;
		n_rules = 0; n_members = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words with checking off, then on with both modes.
		word_queue.push_back(mk(ipacl_pkg::FUNC_LOOKUP, ipacl_pkg::KIND_V4, 0, 0, 0, 0,
			80, 0));
		set_modes(1, 0, 0);
		word_queue.push_back(mk(ipacl_pkg::FUNC_ADD_RULE, ipacl_pkg::KIND_V4, 7, 0,
			128'hFFFF_FFFF_0A00_0000, 128'h0A00_00FF, 0, 16'hFFFF));
		word_queue.push_back(mk(ipacl_pkg::FUNC_ADD_RULE, ipacl_pkg::KIND_V6, 0, 0, V6A,
			V6A + 10, 443, 443));
		word_queue.push_back(mk(ipacl_pkg::FUNC_ADD_RULE, ipacl_pkg::KIND_V6, 1, 0, 0,
			ALL1, 0, 16'hFFFF));
		word_queue.push_back(mk(ipacl_pkg::FUNC_ADD_RULE, ipacl_pkg::KIND_GROUP, 2, 4'hF,
			0, 0, 10, 20));
		word_queue.push_back(mk(ipacl_pkg::FUNC_ADD_RULE, 2'd3, 2, 0, 0, 0, 10, 20));
		word_queue.push_back(mk(ipacl_pkg::FUNC_ADD_MEM, ipacl_pkg::KIND_V4, 0, 4'hF,
			128'h0C00_0000, 128'h0C00_0010, 0, 0));
		word_queue.push_back(mk(ipacl_pkg::FUNC_ADD_MEM, ipacl_pkg::KIND_GROUP, 0, 1,
			0, 0, 0, 0));
		word_queue.push_back(mk(ipacl_pkg::FUNC_ADD_MEM, 2'd3, 0, 1, 0, 0, 0, 0));
		word_queue.push_back(mk(ipacl_pkg::FUNC_LOOKUP, ipacl_pkg::KIND_V4, 7, 0,
			128'h0A00_0005, 0, 16'hFFFF, 0));
		word_queue.push_back(mk(ipacl_pkg::FUNC_LOOKUP, ipacl_pkg::KIND_V6, 0, 0,
			V6A + 10, 0, 443, 0));
		word_queue.push_back(mk(ipacl_pkg::FUNC_LOOKUP, ipacl_pkg::KIND_V6, 1, 0,
			ALL1, 0, 0, 0));
		word_queue.push_back(mk(ipacl_pkg::FUNC_LOOKUP, ipacl_pkg::KIND_V4, 2, 0,
			128'h0C00_0008, 0, 15, 0));
		word_queue.push_back(mk(ipacl_pkg::FUNC_LOOKUP, ipacl_pkg::KIND_GROUP, 2, 0,
			0, 0, 15, 0));
		word_queue.push_back(mk(ipacl_pkg::FUNC_DEL_MEM, ipacl_pkg::KIND_V4, 0, 4'hF,
			128'h0C00_0000, 128'h0C00_0010, 0, 0));
		word_queue.push_back(mk(ipacl_pkg::FUNC_DEL_MEM, ipacl_pkg::KIND_V4, 0, 4'hF,
			128'h0C00_0000, 128'h0C00_0010, 0, 0));
		word_queue.push_back(mk(ipacl_pkg::FUNC_LOOKUP, ipacl_pkg::KIND_V4, 2, 0,
			128'h0C00_0008, 0, 15, 0));
		word_queue.push_back(mk(ipacl_pkg::FUNC_DEL_RULE, ipacl_pkg::KIND_V6, 1, 0, 0,
			ALL1, 0, 16'hFFFF));
		word_queue.push_back(mk(ipacl_pkg::FUNC_DEL_RULE, ipacl_pkg::KIND_V6, 1, 0, 0,
			ALL1, 0, 16'hFFFF));
		word_queue.push_back(mk(ipacl_pkg::FUNC_ADD_RULE, ipacl_pkg::KIND_V6, 1, 0, 0,
			ALL1, 0, 16'hFFFF));
		word_queue.push_back(mk(3'd5, ipacl_pkg::KIND_V4, 0, 0, 0, 0, 0, 0));
		word_queue.push_back(mk(3'd7, ipacl_pkg::KIND_V4, 0, 0, 0, 0, 0, 0));
		set_modes(1, 1, 0);
		word_queue.push_back(mk(ipacl_pkg::FUNC_LOOKUP, ipacl_pkg::KIND_V4, 5, 0, 0, 0,
			9, 0));
		set_modes(1, 0, 1);
		word_queue.push_back(mk(ipacl_pkg::FUNC_LOOKUP, ipacl_pkg::KIND_V4, 5, 0, 0, 0,
			9, 0));
		word_queue.push_back(mk(ipacl_pkg::FUNC_LOOKUP, ipacl_pkg::KIND_GROUP, 5, 0, 0, 0,
			9, 0));

		// Random phases across the mode settings; the rule table fills up
		// through learning so the full cases show up as well.
		for (int ph = 0; ph < 9; ph++) begin
			set_modes(ph != 1, ph == 2 || ph == 7, ph >= 3 && ph != 7);
			if (ph == 4) begin
				// Long receiver stall while words keep coming: the block backs up.
				hold_out = 400;
			end
			for (int k = 0; k < 100; k++) begin
				word_queue.push_back(rand_word());
				if (k == 50) begin
					// Sender stops until every response is in.
					while (word_queue.size() > 0 || in_valid) @(posedge clk);
					sender_paused = 1'b1;
					while (resp_queue.size() > 0) @(posedge clk);
					sender_paused = 1'b0;
				end
				if (word_queue.size() > 8)
					while (word_queue.size() > 2) @(posedge clk);
			end
		end

		wait_drained();
		$display("run covered %0d words under several check, enforce and learn settings,",
			words_sent);
		$display("ending with %0d rules and %0d members in the tables", n_rules, n_members);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#500ms;
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
